### sv/grsd_pkg.sv
// ----------------------------------------------------------------------------
// Gain-ranged sample decoder package
// Shared types and constants for the front decoder, the queue and the
// differential back end.
// ----------------------------------------------------------------------------
package grsd_pkg;

  localparam int unsigned WORD_W     = 16;
  localparam int unsigned VALUE_W    = 32;
  localparam int unsigned FMT_W      = 3;
  localparam int unsigned SHIFT_W    = 5;
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W     = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W     = $clog2(QUEUE_DEPTH + 1);

  localparam logic [FMT_W-1:0] FMT_PLAIN = 3'd0;
  localparam logic [FMT_W-1:0] FMT_GR2   = 3'd1;
  localparam logic [FMT_W-1:0] FMT_GR3   = 3'd2;
  localparam logic [FMT_W-1:0] FMT_GR4   = 3'd3;
  localparam logic [FMT_W-1:0] FMT_LITE  = 3'd4;
  localparam logic [FMT_W-1:0] FMT_DIFF  = 3'd5;

  localparam logic [3:0] EXP_MASK_F1   = 4'h3;
  localparam logic [3:0] EXP_MASK_F2   = 4'h7;
  localparam logic [3:0] EXP_MASK_F3   = 4'hf;
  localparam logic [3:0] EXP_MASK_LITE = 4'h7;
  localparam logic [SHIFT_W-1:0] SHIFT_BASE = 5'd16;

  typedef enum logic [1:0] {
    OP_DIRECT,
    OP_DIFF,
    OP_BAD
  } op_t;

  typedef struct packed {
    op_t                op;
    logic               first;
    logic [VALUE_W-1:0] delta;
    logic [VALUE_W-1:0] start;
  } entry_t;

endpackage

### sv/gain_ranged_sample_decoder_unit.sv
// ----------------------------------------------------------------------------
// Gain-ranged sample decoder unit
// Decodes 16-bit gain-ranged seismic sample words into 32-bit samples.
// ----------------------------------------------------------------------------
// The unit takes one sample per clock cycle while the queue has room and
// returns one result for each sample. Each sample passes through the queue
// and then the output register. The rate is set by one barrel shift in the
// front end and one 32-bit add of the running sum in the back end. A
// four-entry queue between the two parts absorbs output stalls, and the
// input stays ready while the queue has room.
module gain_ranged_sample_decoder_unit import grsd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,  // sample_word [15:0], start_word [31:16]
  input  logic [3:0]  in_tuser,  // format_code [2:0], first_of_block [3]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata, // value [31:0]
  output logic        out_tuser  // bad_format [0]
);

  entry_t front_entry;
  entry_t q_head;
  logic   q_full;
  logic   q_not_empty;
  logic   q_pop;
  logic   q_push;

  assign in_tready = !q_full;
  assign q_push    = in_tvalid && !q_full;

  grsd_front u_front (
    .sample_word    (in_tdata[WORD_W-1:0]),
    .format_code    (in_tuser[FMT_W-1:0]),
    .first_of_block (in_tuser[FMT_W]),
    .start_word     (in_tdata[2*WORD_W-1:WORD_W]),
    .entry          (front_entry)
  );

  grsd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (front_entry),
    .full       (q_full),
    .pop        (q_pop),
    .not_empty  (q_not_empty),
    .head       (q_head)
  );

  grsd_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_not_empty (q_not_empty),
    .q_head      (q_head),
    .q_pop       (q_pop),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_value   (out_tdata),
    .out_bad     (out_tuser)
  );

endmodule

### sv/grsd_front.sv
// ----------------------------------------------------------------------------
// Gain-ranged sample decoder front end
// Accepts sample words, classifies the format and expands the sample word
// and the start word into 32-bit values.
// ----------------------------------------------------------------------------
module grsd_front import grsd_pkg::*; (
  input  logic [WORD_W-1:0] sample_word,
  input  logic [FMT_W-1:0]  format_code,
  input  logic              first_of_block,
  input  logic [WORD_W-1:0] start_word,
  output entry_t            entry
);

  function automatic logic [VALUE_W-1:0] ranged(input logic [WORD_W-1:0] w,
                                                input logic [3:0] emask,
                                                input logic       twice);
    logic [VALUE_W-1:0] wext;
    logic [VALUE_W-1:0] mant;
    logic [SHIFT_W-1:0] e;
    logic [SHIFT_W-1:0] sh;
    wext = {{(VALUE_W-WORD_W){w[WORD_W-1]}}, w};
    mant = wext & ~{{(VALUE_W-4){1'b0}}, emask};
    e    = {1'b0, w[3:0] & emask};
    sh   = twice ? SHIFT_BASE - {e[SHIFT_W-2:0], 1'b0} : SHIFT_BASE - e;
    return mant << sh;
  endfunction

  always_comb begin
    entry.first = first_of_block;
    entry.start = ranged(start_word, EXP_MASK_LITE, 1'b1);
    entry.op    = OP_DIRECT;
    entry.delta = '0;
    case (format_code)
      FMT_PLAIN: begin
        entry.delta = {{(VALUE_W-WORD_W){sample_word[WORD_W-1]}}, sample_word};
      end
      FMT_GR2: begin
        entry.delta = ranged(sample_word, EXP_MASK_F1, 1'b0);
      end
      FMT_GR3: begin
        entry.delta = ranged(sample_word, EXP_MASK_F2, 1'b0);
      end
      FMT_GR4: begin
        entry.delta = ranged(sample_word, EXP_MASK_F3, 1'b0);
      end
      FMT_LITE: begin
        entry.delta = ranged(sample_word, EXP_MASK_LITE, 1'b1);
      end
      FMT_DIFF: begin
        entry.delta = ranged(sample_word, EXP_MASK_LITE, 1'b1);
        entry.op    = OP_DIFF;
      end
      default: begin
        entry.op = OP_BAD;
      end
    endcase
  end

endmodule

### sv/grsd_queue.sv
// ----------------------------------------------------------------------------
// Gain-ranged sample decoder queue
// Small first-in first-out buffer between the front end and the back end.
// ----------------------------------------------------------------------------
module grsd_queue import grsd_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push,
  input  entry_t push_entry,
  output logic   full,
  input  logic   pop,
  output logic   not_empty,
  output entry_t head
);

  entry_t            mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] count_r;

  assign full      = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign not_empty = (count_r != '0);
  assign head      = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

### sv/grsd_back.sv
// ----------------------------------------------------------------------------
// Gain-ranged sample decoder back end
// Applies the differential running sum and holds the result in the output
// register until the transfer completes.
// ----------------------------------------------------------------------------
module grsd_back import grsd_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_not_empty,
  input  entry_t             q_head,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [VALUE_W-1:0] out_value,
  output logic               out_bad
);

  logic               valid_r;
  logic [VALUE_W-1:0] value_r;
  logic               bad_r;
  logic [VALUE_W-1:0] sum_r;
  logic [VALUE_W-1:0] sum_nxt;
  logic [VALUE_W-1:0] value_nxt;

  assign q_pop     = q_not_empty && (!valid_r || out_ready);
  assign out_valid = valid_r;
  assign out_value = value_r;
  assign out_bad   = bad_r;

  always_comb begin
    sum_nxt   = sum_r;
    value_nxt = q_head.delta;
    case (q_head.op)
      OP_DIFF: begin
        sum_nxt   = (q_head.first ? q_head.start : sum_r) + q_head.delta;
        value_nxt = sum_nxt;
      end
      OP_BAD: begin
        value_nxt = '0;
      end
      default: begin
        value_nxt = q_head.delta;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      value_r <= value_nxt;
      bad_r   <= (q_head.op == OP_BAD);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      sum_r   <= '0;
    end else begin
      if (q_pop) begin
        valid_r <= 1'b1;
        sum_r   <= sum_nxt;
      end else if (out_ready) begin
        valid_r <= 1'b0;
      end
    end
  end

endmodule
